// ===== hw/rtl/lfk_pkg.sv =====
// Package for the leg forward kinematics block: widths, CORDIC constants,
// arctangent table and register address codes. No dependencies.
`default_nettype none
package lfk_pkg;
  localparam int unsigned AngleBitsDef    = 16;
  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned MaxStages       = 24;
  localparam int unsigned LenW            = 12;
  localparam int unsigned InAngW          = 16;
  localparam int unsigned OutW            = 15;
  localparam int unsigned PhW             = 33;
  localparam int unsigned CsW             = 33;
  localparam logic signed [CsW-1:0] CordicGain = 33'sd652032874;

  typedef enum logic [1:0] {
    REG_COXA  = 2'd0,
    REG_FEMUR = 2'd1,
    REG_TIBIA = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_e;

  function automatic logic signed [PhW-1:0] atan_lut(input int unsigned i);
    logic signed [PhW-1:0] r;
    begin
      unique case (i)
        0: r = 33'sd536870912;  1: r = 33'sd316933406;  2: r = 33'sd167458907;
        3: r = 33'sd85004756;   4: r = 33'sd42667331;   5: r = 33'sd21354465;
        6: r = 33'sd10679838;   7: r = 33'sd5340245;    8: r = 33'sd2670163;
        9: r = 33'sd1335087;    10: r = 33'sd667544;    11: r = 33'sd333772;
        12: r = 33'sd166886;    13: r = 33'sd83443;     14: r = 33'sd41722;
        15: r = 33'sd20861;     16: r = 33'sd10430;     17: r = 33'sd5215;
        18: r = 33'sd2608;      19: r = 33'sd1304;      20: r = 33'sd652;
        21: r = 33'sd326;       22: r = 33'sd163;       23: r = 33'sd81;
        default: r = '0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/lfk_cordic_cell.sv =====
// One CORDIC rotation cell: rotates x/y by the stage angle, registered.
// Depends on lfk_pkg.
`default_nettype none
module lfk_cordic_cell
  import lfk_pkg::*;
#(
  parameter int unsigned Stage = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic signed [CsW-1:0] x_i,
  input  wire logic signed [CsW-1:0] y_i,
  input  wire logic signed [PhW-1:0] z_i,
  input  wire logic                  neg_i,
  output logic signed [CsW-1:0]      x_o,
  output logic signed [CsW-1:0]      y_o,
  output logic signed [PhW-1:0]      z_o,
  output logic                       neg_o
);
  logic signed [CsW-1:0] xs, ys;
  assign xs = x_i >>> Stage;
  assign ys = y_i >>> Stage;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_o <= neg_i;
      if (!z_i[PhW-1]) begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - atan_lut(Stage);
      end else begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + atan_lut(Stage);
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/lfk_cordic_chain.sv =====
// Chain of CORDIC cells giving cosine and sine in Q30 of a binary angle.
// Depends on lfk_pkg and lfk_cordic_cell.
`default_nettype none
module lfk_cordic_chain
  import lfk_pkg::*;
#(
  parameter int unsigned AngleBits    = AngleBitsDef,
  parameter int unsigned CordicStages = CordicStagesDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [AngleBits-1:0] ang_i,
  output logic signed [CsW-1:0]     cos_o,
  output logic signed [CsW-1:0]     sin_o
);
  logic signed [CsW-1:0] xs [CordicStages+1];
  logic signed [CsW-1:0] ys [CordicStages+1];
  logic signed [PhW-1:0] zs [CordicStages+1];
  logic                  ns [CordicStages+1];
  logic [31:0] ph, phr;
  logic        flip;

  assign ph    = {ang_i, {(32-AngleBits){1'b0}}};
  assign flip  = ph[31] ^ ph[30];
  assign phr   = flip ? (ph + 32'h8000_0000) : ph;
  assign xs[0] = CordicGain;
  assign ys[0] = '0;
  assign zs[0] = {phr[31], phr};
  assign ns[0] = flip;

  for (genvar g = 0; g < CordicStages; g++) begin : g_cell
    lfk_cordic_cell #(.Stage(g)) u_cell (
      .clk_i(clk_i), .en_i(en_i),
      .x_i(xs[g]), .y_i(ys[g]), .z_i(zs[g]), .neg_i(ns[g]),
      .x_o(xs[g+1]), .y_o(ys[g+1]), .z_o(zs[g+1]), .neg_o(ns[g+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= ns[CordicStages] ? -xs[CordicStages] : xs[CordicStages];
      sin_o <= ns[CordicStages] ? -ys[CordicStages] : ys[CordicStages];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/leg_forward_kinematics_top.sv =====
// Top level of the leg forward kinematics block: stream ports, APB
// registers, three CORDIC chains and the arithmetic tail. Depends on lfk_pkg
// and lfk_cordic_chain. One beat per cycle unless the output stalls. Pipe:
// angle prep, CORDIC cells, sign fix, multiply, sum, multiply and rounding.
// The whole pipe advances when the output slot is empty or taken. Lengths
// are read live, so change them only while idle.
`default_nettype none
module leg_forward_kinematics_top
  import lfk_pkg::*;
#(
  parameter int unsigned ANGLE_BITS    = AngleBitsDef,
  parameter int unsigned CORDIC_STAGES = CordicStagesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,  // coxa_angle, femur_angle, tibia_angle
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,  // tip_x, tip_y, tip_z (15b each), pad
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned Lat = CORDIC_STAGES + 6;
  localparam logic [ANGLE_BITS-1:0] Knee =
    ANGLE_BITS'((((64'd791) << ANGLE_BITS) + 64'd1800) / 64'd3600);

  logic [LenW-1:0] coxa_len_q, fem_len_q, tib_len_q;
  logic [Lat-1:0]  vld_q;
  logic            en;
  reg_idx_e        widx;

  assign pready = 1'b1;
  assign widx   = (paddr[3:2] == 2'd0) ? REG_COXA :
                  (paddr[3:2] == 2'd1) ? REG_FEMUR :
                  (paddr[3:2] == 2'd2) ? REG_TIBIA : REG_NONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coxa_len_q <= '0;
      fem_len_q  <= '0;
      tib_len_q  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_COXA:  coxa_len_q <= pwdata[LenW-1:0];
        REG_FEMUR: fem_len_q  <= pwdata[LenW-1:0];
        REG_TIBIA: tib_len_q  <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_COXA:  prdata = {20'd0, coxa_len_q};
      REG_FEMUR: prdata = {20'd0, fem_len_q};
      REG_TIBIA: prdata = {20'd0, tib_len_q};
      default:   prdata = '0;
    endcase
  end

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid_i};
  end

  function automatic logic [ANGLE_BITS-1:0] to_int(input logic [15:0] a);
    logic [ANGLE_BITS+15:0] w;
    begin
      w = {a, {ANGLE_BITS{1'b0}}};
      return w[ANGLE_BITS+15 -: ANGLE_BITS];
    end
  endfunction

  // stage 0: angle prep
  logic [ANGLE_BITS-1:0] ac_q, af_q, ak_q, at;
  assign at = to_int(s_axis_tdata_i[47:32]) - Knee;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ac_q <= to_int(s_axis_tdata_i[15:0]);
      af_q <= to_int(s_axis_tdata_i[31:16]);
      ak_q <= to_int(s_axis_tdata_i[31:16]) + at;
    end
  end

  logic signed [CsW-1:0] cf, sf, ck, sk, cc, sc;
  lfk_cordic_chain #(.AngleBits(ANGLE_BITS), .CordicStages(CORDIC_STAGES)) u_f (
    .clk_i(clk_i), .en_i(en), .ang_i(af_q), .cos_o(cf), .sin_o(sf));
  lfk_cordic_chain #(.AngleBits(ANGLE_BITS), .CordicStages(CORDIC_STAGES)) u_k (
    .clk_i(clk_i), .en_i(en), .ang_i(ak_q), .cos_o(ck), .sin_o(sk));
  lfk_cordic_chain #(.AngleBits(ANGLE_BITS), .CordicStages(CORDIC_STAGES)) u_c (
    .clk_i(clk_i), .en_i(en), .ang_i(ac_q), .cos_o(cc), .sin_o(sc));

  // products of lengths and trig values, their sums and the rounded tip coordinates
  logic signed [46:0] pfc_q, ptc_q, pfs_q, pts_q;
  logic signed [CsW-1:0] cc1_q, sc1_q, cc2_q, sc2_q;
  logic signed [47:0] rx_sum, rz_sum;
  logic signed [29:0] rx_q;
  logic signed [OutW-1:0] rz_q, rz2_q;
  logic signed [62:0] px_q, py_q;
  logic [OutW-1:0] tx_q, ty_q, tz_q;

  assign rx_sum = 48'(pfc_q) + 48'(ptc_q) + (48'($signed({1'b0, coxa_len_q})) <<< 30)
                + 48'sd32768;
  assign rz_sum = 48'(pfs_q) + 48'(pts_q) + (48'sd1 <<< 29);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pfc_q <= 47'($signed({1'b0, fem_len_q})) * 47'(cf);
      ptc_q <= 47'($signed({1'b0, tib_len_q})) * 47'(ck);
      pfs_q <= 47'($signed({1'b0, fem_len_q})) * 47'(sf);
      pts_q <= 47'($signed({1'b0, tib_len_q})) * 47'(sk);
      cc1_q <= cc;  sc1_q <= sc;
      rx_q  <= 30'(rx_sum >>> 16);
      rz_q  <= OutW'(rz_sum >>> 30);
      cc2_q <= cc1_q; sc2_q <= sc1_q;
      px_q  <= 63'(rx_q) * 63'(cc2_q);
      py_q  <= 63'(rx_q) * 63'(sc2_q);
      rz2_q <= rz_q;
      tx_q  <= OutW'((px_q + (63'sd1 <<< 43)) >>> 44);
      ty_q  <= OutW'((py_q + (63'sd1 <<< 43)) >>> 44);
      tz_q  <= rz2_q;
    end
  end

  assign m_axis_tdata_o = {3'b000, tz_q, ty_q, tx_q};

  property p_stall_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o);
  endproperty
  a_stall_hold: assert property (p_stall_hold) else $error("output changed under stall");

  property p_ready_link;
    @(posedge clk_i) disable iff (!rst_ni)
      s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i);
  endproperty
  a_ready_link: assert property (p_ready_link) else $error("ready not tied to output slot");

  property p_valid_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o;
  endproperty
  a_valid_hold: assert property (p_valid_hold) else $error("valid dropped under stall");
endmodule
`default_nettype wire
